@@ rtl/core/xor_checked_frame_receiver_core_defines.svh @@
// assertion helpers shared by the frame receiver core
`ifndef XOR_CHECKED_FRAME_RECEIVER_CORE_DEFINES_SVH
`define XOR_CHECKED_FRAME_RECEIVER_CORE_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define XCFR_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("xcfr same-cycle check failed");

// next-cycle implication
`define XCFR_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("xcfr next-cycle check failed");

`endif

@@ rtl/core/xcfr_pkg.sv @@
package xcfr_pkg;

    localparam logic [7:0] STAR_CHAR         = 8'h2A;
    localparam logic [7:0] NEWLINE_CHAR      = 8'h0A;
    localparam logic [7:0] DIGIT_ZERO        = 8'h30;
    localparam logic [7:0] DIGIT_NINE        = 8'h39;
    localparam logic [1:0] DIGIT_SLOTS       = 2'd3;
    localparam logic [7:0] START_CHAR_RESET  = 8'd35;

    typedef struct packed {
        logic       checksum_ok;
        logic [7:0] computed_xor;
        logic [9:0] received_checksum;
        logic [5:0] frame_length;
        logic       truncated;
    } t_result;

    // handshake between the byte register, the parser and the result register
    typedef struct packed {
        logic advance;
        logic load;
        logic can_take;
    } t_flow;

endpackage

@@ rtl/core/xcfr_ifs.sv @@
interface xcfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface xcfr_result_if;
    logic       valid;
    logic       ready;
    logic       checksum_ok;
    logic [7:0] computed_xor;
    logic [9:0] received_checksum;
    logic [5:0] frame_length;
    logic       truncated;

    modport source (output valid, output checksum_ok, output computed_xor,
                    output received_checksum, output frame_length, output truncated,
                    input ready);
    modport sink   (input valid, input checksum_ok, input computed_xor,
                    input received_checksum, input frame_length, input truncated,
                    output ready);
endinterface

@@ rtl/core/xcfr_in_stage.sv @@
module xcfr_in_stage import xcfr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  t_flow      i_flow,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_byte;

    always_comb begin
        n_valid = r_valid;
        if (i_accept) begin
            n_valid = 1'b1;
        end else if (i_flow.advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

@@ rtl/core/xcfr_parser.sv @@
module xcfr_parser import xcfr_pkg::*; #(
    parameter int FRAME_BUFFER_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic [7:0] i_start_char,
    output logic       o_done,
    output t_result    o_result
);

    localparam int              CW    = $clog2(FRAME_BUFFER_DEPTH);
    localparam logic [CW-1:0]   LIMIT = CW'(FRAME_BUFFER_DEPTH - 1);

    logic          r_in_frame, n_in_frame;
    logic [CW-1:0] r_count,    n_count;
    logic [7:0]    r_xor,      n_xor;
    logic          r_star,     n_star;
    logic [1:0]    r_slots,    n_slots;
    logic          r_stopped,  n_stopped;
    logic [9:0]    r_value,    n_value;

    logic [CW-1:0] upd_count;
    logic [7:0]    upd_xor;
    logic          upd_star;
    logic [1:0]    upd_slots;
    logic          upd_stopped;
    logic [9:0]    upd_value;
    logic          is_digit;
    logic          is_nl;

    always_comb begin
        is_digit    = (i_byte >= DIGIT_ZERO) && (i_byte <= DIGIT_NINE);
        is_nl       = (i_byte == NEWLINE_CHAR);
        upd_count   = r_count + 1'b1;
        upd_xor     = r_xor;
        upd_star    = r_star;
        upd_slots   = r_slots;
        upd_stopped = r_stopped;
        upd_value   = r_value;
        if (r_star) begin
            if (r_slots != DIGIT_SLOTS) begin
                upd_slots = r_slots + 2'd1;
                if (!r_stopped) begin
                    if (is_digit) begin
                        // value * 10 + digit, never above 999
                        upd_value = 10'({r_value, 3'b000} + {r_value, 1'b0}
                                        + {6'd0, i_byte[3:0]});
                    end else begin
                        upd_stopped = 1'b1;
                    end
                end
            end
        end else if (i_byte == STAR_CHAR) begin
            upd_star = 1'b1;
        end else begin
            upd_xor = r_xor ^ i_byte;
        end
    end

    always_comb begin
        n_in_frame = r_in_frame;
        n_count    = r_count;
        n_xor      = r_xor;
        n_star     = r_star;
        n_slots    = r_slots;
        n_stopped  = r_stopped;
        n_value    = r_value;
        o_done     = 1'b0;
        if (i_byte == i_start_char) begin
            // open or restart
            n_in_frame = 1'b1;
            n_count    = CW'(1);
            n_xor      = '0;
            n_star     = 1'b0;
            n_slots    = '0;
            n_stopped  = 1'b0;
            n_value    = '0;
        end else if (r_in_frame) begin
            o_done = is_nl || (upd_count >= LIMIT);
            if (o_done) begin
                n_in_frame = 1'b0;
                n_count    = '0;
                n_xor      = '0;
                n_star     = 1'b0;
                n_slots    = '0;
                n_stopped  = 1'b0;
                n_value    = '0;
            end else begin
                n_count    = upd_count;
                n_xor      = upd_xor;
                n_star     = upd_star;
                n_slots    = upd_slots;
                n_stopped  = upd_stopped;
                n_value    = upd_value;
            end
        end
    end

    always_comb begin
        o_result.checksum_ok       = (upd_value == {2'b00, upd_xor});
        o_result.computed_xor      = upd_xor;
        o_result.received_checksum = upd_value;
        o_result.frame_length      = 6'(upd_count);
        o_result.truncated         = !is_nl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_count    <= '0;
            r_xor      <= '0;
            r_star     <= 1'b0;
            r_slots    <= '0;
            r_stopped  <= 1'b0;
            r_value    <= '0;
        end else if (i_step) begin
            r_in_frame <= n_in_frame;
            r_count    <= n_count;
            r_xor      <= n_xor;
            r_star     <= n_star;
            r_slots    <= n_slots;
            r_stopped  <= n_stopped;
            r_value    <= n_value;
        end
    end

endmodule

@@ rtl/core/xcfr_out_reg.sv @@
module xcfr_out_reg import xcfr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_flow   i_flow,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_can_take,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_can_take = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_flow.load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_flow.load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

@@ rtl/core/xor_checked_frame_receiver_core.sv @@
// path: an accepted byte is held in the byte register until the parser takes it;
//   the result beat of a closing byte is registered in the result register that drives o_res
// throughput: one byte per cycle, limited only by result beats stalled on o_res
// reset: synchronous active-low i_rst_n clears frame state, empties both
//   registers and sets start_char to '#' (35)
`include "xor_checked_frame_receiver_core_defines.svh"

module xor_checked_frame_receiver_core import xcfr_pkg::*; #(
    parameter int FRAME_BUFFER_DEPTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [7:0]           i_cfg_wdata,
    xcfr_byte_if.sink            i_rx,
    xcfr_result_if.source        o_res
);

    localparam logic [5:0] LIMIT_LOW = 6'(FRAME_BUFFER_DEPTH - 1);

    logic [7:0] r_start;
    logic       in_valid;
    logic [7:0] in_byte;
    logic       done;
    t_result    parsed;
    t_result    out_result;
    t_flow      flow;
    logic       can_take;
    logic       accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= START_CHAR_RESET;
        end else if (i_cfg_we) begin
            r_start <= i_cfg_wdata;
        end
    end

    // a byte that closes a frame waits until the result register is free
    assign flow.can_take = can_take;
    assign flow.advance  = in_valid && (!done || can_take);
    assign flow.load     = flow.advance && done;
    assign i_rx.ready    = !in_valid || flow.advance;
    assign accept        = i_rx.valid && i_rx.ready;

    xcfr_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_byte  (i_rx.rx_byte),
        .i_flow  (flow),
        .o_valid (in_valid),
        .o_byte  (in_byte)
    );

    xcfr_parser #(
        .FRAME_BUFFER_DEPTH(FRAME_BUFFER_DEPTH)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (flow.advance),
        .i_byte      (in_byte),
        .i_start_char(r_start),
        .o_done      (done),
        .o_result    (parsed)
    );

    xcfr_out_reg u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_flow    (flow),
        .i_result  (parsed),
        .i_ready   (o_res.ready),
        .o_can_take(can_take),
        .o_valid   (o_res.valid),
        .o_result  (out_result)
    );

    assign o_res.checksum_ok       = out_result.checksum_ok;
    assign o_res.computed_xor      = out_result.computed_xor;
    assign o_res.received_checksum = out_result.received_checksum;
    assign o_res.frame_length      = out_result.frame_length;
    assign o_res.truncated         = out_result.truncated;

    `XCFR_ASSERT_IMP(a_ok_matches, o_res.valid, o_res.checksum_ok == (o_res.received_checksum == {2'b00, o_res.computed_xor}))
    `XCFR_ASSERT_IMP(a_trunc_len, o_res.valid && o_res.truncated, o_res.frame_length == LIMIT_LOW)
    `XCFR_ASSERT_IMP(a_value_range, o_res.valid, o_res.received_checksum <= 10'd999)
    `XCFR_ASSERT_NXT(a_in_hold, in_valid && !flow.advance, in_valid && $stable(in_byte))

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import xcfr_pkg::*;

    localparam int RX_DEPTH      = 64;
    localparam int FRAME_LIMIT   = RX_DEPTH - 1;
    localparam int PHASE_ITEMS   = 80;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 300;
    localparam int DIR_ROWS      = 26;

    typedef enum logic [1:0] {ROW_QUIET, ROW_MODEL, ROW_REPORT} t_row_kind;

    typedef struct packed {
        logic [7:0] data;
        t_row_kind  kind;
        t_result    want;
    } t_table_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [7:0] i_cfg_wdata;

    xcfr_byte_if   rx_bus ();
    xcfr_result_if res_bus ();

    xor_checked_frame_receiver_core #(
        .FRAME_BUFFER_DEPTH(RX_DEPTH)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_rx       (rx_bus),
        .o_res      (res_bus)
    );

    always #5 i_clk = ~i_clk;

    // frame parser mirror
    logic [7:0] start_sel;
    bit         frame_open;
    int         frame_count;
    logic [7:0] frame_xor;
    bit         star_hit;
    int         slots_used;
    bit         digits_done;
    int         csum_value;

    t_result    pending_reports [$];
    t_table_row dir_rows [DIR_ROWS];
    int         mismatches = 0;
    int         items_phase;
    bit         steady = 1'b0;
    bit         hold_req = 1'b0;

    function automatic void clear_parser();
        frame_open  = 1'b0;
        frame_count = 0;
        frame_xor   = '0;
        star_hit    = 1'b0;
        slots_used  = 0;
        digits_done = 1'b0;
        csum_value  = 0;
    endfunction

    task automatic parse_rx_byte(input logic [7:0] b, output bit has_report,
                                 output t_result rpt, output bit counted);
        has_report = 1'b0;
        counted    = 1'b0;
        rpt        = '0;
        if (b == start_sel) begin
            clear_parser();
            frame_open  = 1'b1;
            frame_count = 1;
            counted     = 1'b1;
        end else if (frame_open) begin
            counted = 1'b1;
            frame_count++;
            if (star_hit) begin
                if (slots_used < DIGIT_SLOTS) begin
                    slots_used++;
                    if (!digits_done) begin
                        if (b >= DIGIT_ZERO && b <= DIGIT_NINE)
                            csum_value = csum_value * 10 + int'(b - DIGIT_ZERO);
                        else
                            digits_done = 1'b1;
                    end
                end
            end else if (b == STAR_CHAR) begin
                star_hit = 1'b1;
            end else begin
                frame_xor ^= b;
            end
            if (b == NEWLINE_CHAR || frame_count >= FRAME_LIMIT) begin
                has_report            = 1'b1;
                rpt.checksum_ok       = (csum_value == int'(frame_xor));
                rpt.computed_xor      = frame_xor;
                rpt.received_checksum = csum_value[9:0];
                rpt.frame_length      = frame_count[5:0];
                rpt.truncated         = (b != NEWLINE_CHAR);
                clear_parser();
            end
        end
    endtask

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_body_byte();
        logic [7:0] b;
        do begin
            if ($urandom_range(0, 3) == 0)
                b = 8'($urandom_range(0, 255));
            else
                b = 8'($urandom_range(8'h20, 8'h7E));
        end while (b == start_sel || b == STAR_CHAR || b == NEWLINE_CHAR);
        return b;
    endfunction

    // offer one beat, wait for it to be taken, then update the mirror
    task automatic push_byte(input logic [7:0] b, input t_row_kind kind, input t_result want);
        int gap;
        bit has_report;
        bit counted;
        t_result rpt;
        gap = pick_gap();
        if (gap > 0) begin
            rx_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_bus.valid   <= 1'b1;
        rx_bus.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_bus.ready) @(posedge i_clk);
        parse_rx_byte(b, has_report, rpt, counted);
        if (counted)
            items_phase++;
        case (kind)
            ROW_REPORT: pending_reports.push_back(want);
            ROW_MODEL: begin
                if (has_report)
                    pending_reports.push_back(rpt);
            end
            default: ;
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b);
        push_byte(b, ROW_MODEL, '0);
    endtask

    task automatic send_frame();
        int body_len;
        int val;
        int ndig;
        logic [7:0] b;
        logic [7:0] sum;
        sum = '0;
        send_byte(start_sel);
        body_len = $urandom_range(0, 8);
        repeat (body_len) begin
            b = pick_body_byte();
            sum ^= b;
            send_byte(b);
        end
        send_byte(STAR_CHAR);
        val  = ($urandom_range(0, 3) != 0) ? int'(sum) : $urandom_range(0, 999);
        ndig = (val >= 100) ? 3 : (val >= 10) ? 2 : 1;
        if ($urandom_range(0, 4) == 0)
            ndig = 3;
        for (int k = ndig - 1; k >= 0; k--)
            send_byte(DIGIT_ZERO + 8'((val / ((k == 2) ? 100 : (k == 1) ? 10 : 1)) % 10));
        if ($urandom_range(0, 9) == 0)
            send_byte(pick_body_byte());
        send_byte(NEWLINE_CHAR);
    endtask

    task automatic send_burst();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            send_frame();
        end else if (r < 70) begin
            // newline just short of the length limit, right at it, or a run past it
            send_byte(start_sel);
            repeat ($urandom_range(59, 64)) send_byte(pick_body_byte());
            send_byte(NEWLINE_CHAR);
        end else if (r < 85) begin
            send_byte(start_sel);
            repeat ($urandom_range(0, 4)) send_byte(pick_body_byte());
            case ($urandom_range(0, 2))
                0: send_frame();
                1: begin
                    send_byte(STAR_CHAR);
                    repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
                    send_byte(NEWLINE_CHAR);
                end
                default: ;
            endcase
        end else begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic drain_and_settle();
        rx_bus.valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_start_char(input logic [7:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        start_sel = v;
    endtask

    task automatic check_field(input string name, input logic [9:0] want,
                               input logic [9:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : report_check
        t_result want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (pending_reports.size() == 0) begin
                $error("result beat with nothing pending: xor %0d len %0d",
                       res_bus.computed_xor, res_bus.frame_length);
                mismatches++;
            end else begin
                want = pending_reports.pop_front();
                check_field("checksum_ok", 10'(want.checksum_ok), 10'(res_bus.checksum_ok));
                check_field("computed_xor", 10'(want.computed_xor),
                            10'(res_bus.computed_xor));
                check_field("received_checksum", want.received_checksum,
                            res_bus.received_checksum);
                check_field("frame_length", 10'(want.frame_length),
                            10'(res_bus.frame_length));
                check_field("truncated", 10'(want.truncated), 10'(res_bus.truncated));
            end
        end
    end

    initial begin : res_ready_drive
        int stall;
        int hold;
        stall = 0;
        hold  = 0;
        res_bus.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold     = HOLD_CYCLES;
            end
            if (hold > 0) begin
                res_bus.ready <= 1'b0;
                hold--;
            end else if (stall > 0) begin
                res_bus.ready <= 1'b0;
                stall--;
            end else begin
                res_bus.ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    initial begin : stimulus
        logic [7:0] phase_chars [6];
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        rx_bus.valid   = 1'b0;
        rx_bus.rx_byte = '0;
        clear_parser();
        start_sel   = START_CHAR_RESET;
        phase_chars = '{8'hFF, 8'h00, STAR_CHAR, NEWLINE_CHAR,
                        8'($urandom_range(0, 255)), START_CHAR_RESET};
        dir_rows = '{
            '{8'h41,        ROW_QUIET,  '0},  // ignored while idle
            '{8'h23,        ROW_QUIET,  '0},
            '{8'h41,        ROW_QUIET,  '0},
            '{STAR_CHAR,    ROW_QUIET,  '0},
            '{8'h36,        ROW_QUIET,  '0},
            '{8'h35,        ROW_QUIET,  '0},
            '{NEWLINE_CHAR, ROW_REPORT, '{1'b1, 8'h41, 10'd65, 6'd6, 1'b0}},
            '{8'h23,        ROW_QUIET,  '0},
            '{8'hFF,        ROW_QUIET,  '0},
            '{8'h00,        ROW_QUIET,  '0},
            '{8'h23,        ROW_QUIET,  '0},  // restart inside a frame
            '{NEWLINE_CHAR, ROW_REPORT, '{1'b0, 8'h0A, 10'd0, 6'd2, 1'b0}},
            '{8'h23,        ROW_QUIET,  '0},
            '{8'h5A,        ROW_MODEL,  '0},
            '{STAR_CHAR,    ROW_MODEL,  '0},
            '{8'h39,        ROW_MODEL,  '0},
            '{8'h39,        ROW_MODEL,  '0},
            '{8'h39,        ROW_MODEL,  '0},
            '{8'h37,        ROW_MODEL,  '0},  // past the digit slots
            '{STAR_CHAR,    ROW_MODEL,  '0},
            '{NEWLINE_CHAR, ROW_REPORT, '{1'b0, 8'h5A, 10'd999, 6'd9, 1'b0}},
            '{8'h23,        ROW_MODEL,  '0},
            '{STAR_CHAR,    ROW_MODEL,  '0},
            '{8'h78,        ROW_MODEL,  '0},  // non-digit stops the number
            '{8'h35,        ROW_MODEL,  '0},
            '{NEWLINE_CHAR, ROW_MODEL,  '0}
        };
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir_rows[i])
            push_byte(dir_rows[i].data, dir_rows[i].kind, dir_rows[i].want);
        for (int p = 0; p < 6; p++) begin
            drain_and_settle();
            write_start_char(phase_chars[p]);
            steady = (p == 1);
            if (p == 5)
                hold_req = 1'b1;
            items_phase = 0;
            while (items_phase < PHASE_ITEMS)
                send_burst();
        end
        drain_and_settle();
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
